>>> src/seq_ack_window_tracker_top_macros.svh
// Assertion macros used by the checker file.
`ifndef SEQ_ACK_WINDOW_TRACKER_TOP_MACROS_SVH
`define SEQ_ACK_WINDOW_TRACKER_TOP_MACROS_SVH

// Assert that a condition implies a property in the same cycle.
`define SAWT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Assert that a condition implies a property in the next cycle.
`define SAWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/sawt_pkg.sv
`default_nettype none
package sawt_pkg;

   localparam int WindowBits = 64;
   localparam int CountBits  = $clog2(WindowBits + 1);

   typedef struct packed {
      logic [31:0] seq_number;
      logic [31:0] ack_number;
      logic [63:0] ack_mask;
   } req_type;

   typedef struct packed {
      logic [7:0]  recv_loss_count;
      logic [7:0]  send_loss_count;
      logic        ack_itself_new;
      logic [31:0] mask_base;
      logic [63:0] new_ack_bits;
      logic [63:0] spilled_ack_bits;
      logic        old_ack_outside;
   } rsp_type;

   // Classified request passed from the front part to the back part.
   typedef struct packed {
      req_type     req;
      logic [63:0] mask;
   } work_type;

   // Mask of the window width.
   function automatic logic [63:0] win_mask();
      logic [63:0] m;
      m = '0;
      for (int i = 0; i < WindowBits; i++) m[i] = 1'b1;
      return m;
   endfunction

   // Population count of a 64-bit word.
   function automatic logic [CountBits-1:0] ones_in(input logic [63:0] x);
      logic [CountBits-1:0] c;
      c = '0;
      for (int i = 0; i < 64; i++) c = c + CountBits'(x[i]);
      return c;
   endfunction

   // Shift a history window by gap d, marking the previous newest number in it.
   function automatic logic [63:0] adv_hist(input logic [63:0] h, input logic [31:0] d);
      logic [63:0] r;
      r = (d >= 32'd64) ? 64'd0 : (h << d[5:0]);
      if (d <= 32'd64) r = r | (64'd1 << 6'(d - 32'd1));
      return r & win_mask();
   endfunction

   function automatic logic [7:0] adv_loss(input logic [63:0] h, input logic [31:0] d,
                                           input logic counting);
      logic [6:0]  k;
      logic [63:0] top;
      logic [32:0] z;
      k   = (d < 32'(WindowBits)) ? 7'(d) : 7'(WindowBits);
      top = (k == 7'd0) ? 64'd0 : ((h & win_mask()) >> (7'(WindowBits) - k));
      z   = 33'(k) - 33'(ones_in(top));
      if (d > 32'(WindowBits + 1)) z = z + 33'(d) - 33'(WindowBits + 1);
      if (!counting) z = '0;
      return (z > 33'd255) ? 8'd255 : z[7:0];
   endfunction

endpackage
`default_nettype wire

>>> src/sawt_if.sv
`default_nettype none
interface sawt_req_if;
   logic               valid;
   logic               ready;
   sawt_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sawt_rsp_if;
   logic               valid;
   logic               ready;
   sawt_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/sawt_front.sv
`default_nettype none
module sawt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   sawt_req_if.sink                 req,
   output sawt_pkg::work_type       work_ff,
   output logic                     work_valid_ff,
   input  wire logic                work_ready
);

   sawt_pkg::work_type work_in;
   logic               work_valid_in;

   // Two-entry skid queue: a register plus a spare.
   sawt_pkg::work_type spare_ff, spare_in;
   logic               spare_valid_ff, spare_valid_in;

   assign req.ready = !spare_valid_ff;

   // Classify: keep only the window bits of the mask.
   sawt_pkg::work_type incoming;
   always_comb begin
      incoming.req  = req.payload;
      incoming.mask = req.payload.ack_mask & sawt_pkg::win_mask();
   end

   always_comb begin
      work_in        = work_ff;
      work_valid_in  = work_valid_ff;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      if (work_ready || !work_valid_ff) begin
         if (spare_valid_ff) begin
            work_in        = spare_ff;
            work_valid_in  = 1'b1;
            spare_valid_in = 1'b0;
         end else begin
            work_in       = incoming;
            work_valid_in = req.valid;
         end
      end else if (req.valid && req.ready) begin
         spare_in       = incoming;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      spare_ff <= spare_in;
      if (reset) begin
         work_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         work_valid_ff  <= work_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

endmodule
`default_nettype wire

>>> src/sawt_back.sv
`default_nettype none
module sawt_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire sawt_pkg::work_type  work,
   input  wire logic                work_valid,
   output logic                     work_ready,
   sawt_rsp_if.source               rsp
);

   logic [31:0] newest_seq_ff, newest_seq_in;
   logic [63:0] seq_hist_ff, seq_hist_in;
   logic [31:0] newest_ack_ff, newest_ack_in;
   logic [63:0] ack_hist_ff, ack_hist_in;
   sawt_pkg::rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        take;

   assign work_ready = !rsp_valid_ff || rsp.ready;
   assign take       = work_valid && work_ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // Update both windows and form the response.
   always_comb begin
      logic [31:0] seq, ack, d, last;
      logic [63:0] cur, res, keep, wm;
      seq  = work.req.seq_number;
      ack  = work.req.ack_number;
      wm   = sawt_pkg::win_mask();
      d    = '0;
      last = '0;
      keep = '0;
      newest_seq_in = newest_seq_ff;
      seq_hist_in   = seq_hist_ff;
      newest_ack_in = newest_ack_ff;
      rsp_in        = '0;
      // Sequence window.
      if (seq > newest_seq_ff) begin
         last = newest_seq_ff;
         newest_seq_in = seq;
         if (last != 32'd0) begin
            d = seq - last;
            rsp_in.recv_loss_count = sawt_pkg::adv_loss(seq_hist_ff, d,
                                        last > 32'(sawt_pkg::WindowBits - 1));
            seq_hist_in = sawt_pkg::adv_hist(seq_hist_ff, d);
         end
      end else if (seq < newest_seq_ff) begin
         d = newest_seq_ff - seq - 32'd1;
         if (d < 32'(sawt_pkg::WindowBits))
            seq_hist_in = (seq_hist_ff | (64'd1 << d[5:0])) & wm;
      end
      // Acknowledge window.
      cur = ack_hist_ff & wm;
      res = cur | work.mask;
      if (ack > newest_ack_ff) begin
         last = newest_ack_ff;
         newest_ack_in = ack;
         rsp_in.ack_itself_new = 1'b1;
         if (last != 32'd0) begin
            d = ack - last;
            rsp_in.send_loss_count = sawt_pkg::adv_loss(cur, d,
                                        last > 32'(sawt_pkg::WindowBits - 1));
            cur = sawt_pkg::adv_hist(cur, d);
         end
         res = cur | work.mask;
      end else if (ack < newest_ack_ff) begin
         d   = newest_ack_ff - ack - 32'd1;
         res = cur;
         if (d < 32'(sawt_pkg::WindowBits)) begin
            // Mask bits that land at or beyond the window top are spilled.
            keep = (64'd1 << 6'(32'(sawt_pkg::WindowBits) - d - 32'd1)) - 64'd1;
            res = res | (64'd1 << d[5:0]);
            res = res | (((d == 32'd63) ? 64'd0 : (work.mask << 6'(d + 32'd1))) & wm);
            rsp_in.spilled_ack_bits = work.mask & ~keep;
         end else begin
            rsp_in.old_ack_outside  = 1'b1;
            rsp_in.spilled_ack_bits = work.mask;
         end
      end
      res = res & wm;
      ack_hist_in = res;
      rsp_in.mask_base    = newest_ack_in;
      rsp_in.new_ack_bits = res ^ cur;
      rsp_valid_in = take ? 1'b1 : (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (take) rsp_ff <= rsp_in;
      if (reset) begin
         newest_seq_ff <= '0;
         seq_hist_ff   <= '0;
         newest_ack_ff <= '0;
         ack_hist_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            newest_seq_ff <= newest_seq_in;
            seq_hist_ff   <= seq_hist_in;
            newest_ack_ff <= newest_ack_in;
            ack_hist_ff   <= ack_hist_in;
         end
      end
   end

endmodule
`default_nettype wire

>>> src/seq_ack_window_tracker_top.sv
// Request path: work register, then combinational shift and popcount, then response register.
// Throughput: one request per cycle unless the response side stalls.
// A two-entry queue lets the request side run on while the response side stalls.
// Reset (synchronous, active high) clears both windows and empties the queue and output.
`default_nettype none
module seq_ack_window_tracker_top (
   input  wire logic   clock,
   input  wire logic   reset,
   sawt_req_if.sink    req,
   sawt_rsp_if.source  rsp
);

   sawt_pkg::work_type work;
   logic               work_valid;
   logic               work_ready;

   // Front part: accepts and queues requests.
   sawt_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .work_ff       (work),
      .work_valid_ff (work_valid),
      .work_ready    (work_ready)
   );

   // Back part: updates windows and holds the response.
   sawt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .work       (work),
      .work_valid (work_valid),
      .work_ready (work_ready),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire

>>> src/sawt_checker.sv
`default_nettype none
`include "seq_ack_window_tracker_top_macros.svh"
module sawt_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire sawt_pkg::rsp_type rsp_payload
);

   // A waiting response stays until taken.
   `SAWT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response dropped while stalled")
   // A newer ack never spills mask bits or lies outside the window.
   `SAWT_ASSERT_IMP(a_spill_new, clock, reset, rsp_valid && rsp_payload.ack_itself_new, rsp_payload.spilled_ack_bits == 64'd0 && !rsp_payload.old_ack_outside, "spill on newer ack")
   // An old ack beyond the window leaves the history untouched.
   `SAWT_ASSERT_IMP(a_outside_quiet, clock, reset, rsp_valid && rsp_payload.old_ack_outside, rsp_payload.new_ack_bits == 64'd0 && rsp_payload.send_loss_count == 8'd0, "history changed by outside ack")
   // Send losses only come with a newer ack.
   `SAWT_ASSERT_IMP(a_loss_new, clock, reset, rsp_valid && rsp_payload.send_loss_count != 8'd0, rsp_payload.ack_itself_new, "send loss without newer ack")

endmodule

bind seq_ack_window_tracker_top sawt_checker u_sawt_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_payload (rsp.payload)
);
`default_nettype wire
